### rtl/iirl_pkg.sv
// Shared constants, codes and types for the indexed insert/remove list.
`default_nettype none
package iirl_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 64;
  localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = 5;
  localparam int OP_BITS   = 3;
  localparam int POS_BITS  = 5;
  localparam int VAL_BITS  = 64;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_PUSH   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/iirl_cell.sv
// One list slot: loads a new word or takes the word of a neighbor slot.
`default_nettype none
module iirl_cell (
  input  wire logic                           clk,
  input  wire iirl_pkg::cell_ctl_t            ctl,
  input  wire logic [iirl_pkg::WORD_BITS-1:0] value,
  input  wire logic [iirl_pkg::WORD_BITS-1:0] lower,
  input  wire logic [iirl_pkg::WORD_BITS-1:0] upper,
  output logic      [iirl_pkg::WORD_BITS-1:0] data
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= value;
    end else if (ctl.shift_up) begin
      data <= lower;
    end else if (ctl.shift_down) begin
      data <= upper;
    end
  end

endmodule
`default_nettype wire

### rtl/indexed_insert_remove_list.sv
// Top level of the indexed insert/remove list: request decode, slot row, result register.
//
// A fixed-capacity ordered list of DEPTH words held in a row of slots. Each
// request (insert, remove, read, write, push back, clear) is taken when start
// is high and busy is low; busy never rises, so a request may be issued every
// cycle. On insert every slot above the index takes the word of its lower
// neighbor, on remove every slot from the index up takes the word of its
// upper neighbor, all in the same clock edge. The result word appears on
// read_value, status and fill_count with done high for exactly one cycle, the
// cycle after the request is taken, and must be captured then. Out-of-range
// positions return status 1, an insert or push back into a full list returns
// status 2, and neither changes the list.
`default_nettype none
module indexed_insert_remove_list (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [iirl_pkg::OP_BITS-1:0]   opcode,
  input  wire logic [iirl_pkg::POS_BITS-1:0]  position,
  input  wire logic [iirl_pkg::VAL_BITS-1:0]  value,
  output logic                                done,
  output logic      [iirl_pkg::VAL_BITS-1:0]  read_value,
  output logic      [1:0]                     status,
  output logic      [iirl_pkg::CNT_BITS-1:0]  fill_count
);

  localparam int D  = iirl_pkg::DEPTH;
  localparam int W  = iirl_pkg::WORD_BITS;
  localparam int CB = iirl_pkg::CNT_BITS;

  logic [CB-1:0]             count;
  logic [CB-1:0]             count_next;
  logic [W-1:0]              cell_data [D];
  iirl_pkg::cell_ctl_t       cell_ctl  [D];
  logic [W-1:0]              word_in;
  iirl_pkg::op_t             op;
  logic                      accept;
  logic                      do_ins;
  logic                      do_rem;
  logic                      do_wr;
  logic [CB-1:0]             tgt;
  logic [W-1:0]              rd;
  iirl_pkg::status_t         st;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign op      = iirl_pkg::op_t'(opcode);
  assign word_in = value[W-1:0];

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_wr      = 1'b0;
    tgt        = position;
    rd         = '0;
    st         = iirl_pkg::ST_OK;
    count_next = count;
    case (op)
      iirl_pkg::OP_INSERT, iirl_pkg::OP_PUSH: begin
        if (op == iirl_pkg::OP_PUSH) begin
          tgt = count;
        end
        if (tgt > count) begin
          st = iirl_pkg::ST_RANGE;
        end else if (count >= CB'(D)) begin
          st = iirl_pkg::ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CB'(1);
        end
      end
      iirl_pkg::OP_REMOVE, iirl_pkg::OP_READ, iirl_pkg::OP_WRITE: begin
        if (position >= count) begin
          st = iirl_pkg::ST_RANGE;
        end else begin
          if (op != iirl_pkg::OP_WRITE) begin
            rd = cell_data[position[iirl_pkg::IDX_BITS-1:0]];
          end
          if (op == iirl_pkg::OP_REMOVE) begin
            do_rem     = 1'b1;
            count_next = count - CB'(1);
          end
          if (op == iirl_pkg::OP_WRITE) begin
            do_wr = 1'b1;
          end
        end
      end
      iirl_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [W-1:0] lower;
    logic [W-1:0] upper;
    logic         at_tgt;
    logic         above_tgt;

    assign at_tgt    = (CB'(i) == tgt);
    assign above_tgt = (CB'(i) > tgt);

    assign cell_ctl[i].load       = accept && (do_ins || do_wr) && at_tgt;
    assign cell_ctl[i].shift_up   = accept && do_ins && above_tgt;
    assign cell_ctl[i].shift_down = accept && do_rem && (above_tgt || at_tgt);

    if (i == 0) begin : g_lo_end
      assign lower = word_in;
    end else begin : g_lo
      assign lower = cell_data[i-1];
    end
    if (i == D - 1) begin : g_hi_end
      assign upper = cell_data[i];
    end else begin : g_hi
      assign upper = cell_data[i+1];
    end

    iirl_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[i]),
      .value (word_in),
      .lower (lower),
      .upper (upper),
      .data  (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= iirl_pkg::VAL_BITS'(rd);
      status     <= st;
      fill_count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CB'(D))
    else $error("fill count above capacity");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    done |-> fill_count == count)
    else $error("reported fill count differs from held count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == iirl_pkg::ST_FULL) |-> fill_count == CB'(D))
    else $error("full status with list not full");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != iirl_pkg::ST_OK) |-> read_value == '0)
    else $error("nonzero read word on error");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && st != iirl_pkg::ST_OK) |=> count == $past(count))
    else $error("count changed on failed request");

endmodule
`default_nettype wire
